// ----- rtl/mtvf_pkg.sv -----
package mtvf_pkg;

    localparam int TRACK_SLOTS_DEF = 8;
    localparam int DELAY_SLOTS_DEF = 4;
    localparam logic [14:0] VOL_MAX = 15'd25600;

    typedef enum logic [2:0] {
        M_TICK      = 3'd0,
        M_FADE_IN   = 3'd1,
        M_FADE_DLY  = 3'd2,
        M_FADE_OUT  = 3'd3,
        M_FADE_VOL  = 3'd4,
        M_OUT_ALL   = 3'd5,
        M_STOP_ALL  = 3'd6,
        M_UNUSED    = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        A_SET_VOL  = 3'd0,
        A_START    = 3'd1,
        A_STOP     = 3'd2,
        A_NOT_PLAY = 3'd3,
        A_NO_SLOT  = 3'd4
    } t_action;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  sound;
        logic [15:0] duration_ms;
        logic [14:0] volume;
        logic [15:0] amount;
        logic [15:0] delay_ms;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  slot;
        logic [7:0]  sound_out;
        logic [14:0] volume_out;
        logic        last;
    } t_res;

endpackage

// ----- rtl/mtvf_if.sv -----
interface mtvf_cmd_if;
    logic              valid;
    logic              ready;
    mtvf_pkg::t_cmd    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mtvf_res_if;
    logic              valid;
    logic              ready;
    mtvf_pkg::t_res    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/mtvf_div.sv -----
// Restoring divider, one quotient bit per cycle: 48-bit dividend / 32-bit divisor.
module mtvf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [47:0] o_quo
);
    logic [47:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_trial;
    logic [32:0] n_shift;

    always_comb begin
        n_shift = {r_rem[31:0], r_q[47]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd48;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!n_trial[32]) begin
                    r_rem <= n_trial;
                    r_q   <= {r_q[46:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_q   <= {r_q[46:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

// ----- rtl/multi_track_volume_fader.sv -----
// Multi-track volume fader. Each command is one transaction on i_cmd; results leave on
// o_res, the final one of a command flagged by last. One result is held back until the
// next one appears or the command ends, so that last can be set on the right one.
// A tick walks the track slots one per step. A slot mid-ramp runs one pass of the
// shared restoring divider and emits its new volume, a slot that reaches its target
// emits that target, and any other slot emits nothing. Delayed starts are then
// scanned one per cycle while none fires; each start that fires goes through the
// start step and emits a result. Receiver stalls hold the block while a result
// waits to be taken. The block takes no new command until the current one is
// finished and its last result taken.
module multi_track_volume_fader #(
    parameter int TRACK_SLOTS = mtvf_pkg::TRACK_SLOTS_DEF,
    parameter int DELAY_SLOTS = mtvf_pkg::DELAY_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtvf_cmd_if.sink   i_cmd,
    mtvf_res_if.source o_res
);
    import mtvf_pkg::*;

    localparam int TW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int DW = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_TSLOT = 10'b0000000100,
        S_TDIV  = 10'b0000001000,
        S_TPEND = 10'b0000010000,
        S_START = 10'b0000100000,
        S_FIND  = 10'b0001000000,
        S_SCAN  = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_state;

    t_state r_state, r_ret;
    t_cmd   r_cmd;

    logic [31:0] r_now;
    logic [TRACK_SLOTS-1:0] r_used, r_ending;
    logic [7:0]  r_snd   [TRACK_SLOTS];
    logic [14:0] r_from  [TRACK_SLOTS];
    logic [14:0] r_to    [TRACK_SLOTS];
    logic [14:0] r_vnow  [TRACK_SLOTS];
    logic [31:0] r_beg   [TRACK_SLOTS];
    logic [31:0] r_fin   [TRACK_SLOTS];
    logic [DELAY_SLOTS-1:0] r_pused;
    logic [7:0]  r_psnd  [DELAY_SLOTS];
    logic [15:0] r_plen  [DELAY_SLOTS];
    logic [14:0] r_plvl  [DELAY_SLOTS];
    logic [31:0] r_pdue  [DELAY_SLOTS];

    logic [TW:0] r_ti;
    logic [DW:0] r_pi;
    logic        r_ovalid;
    t_res        r_res;
    t_res        r_hold;
    logic        r_hold_v;

    // start request held for the shared start step
    logic [7:0]  r_ssnd;
    logic [15:0] r_sdur;
    logic [14:0] r_slvl;

    // divider
    logic        r_dstart;
    logic [47:0] r_num;
    logic [31:0] r_den;
    logic        w_ddone;
    logic [47:0] w_quo;

    mtvf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_dstart),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_done (w_ddone),
        .o_quo  (w_quo)
    );

    logic [TW-1:0] w_t;
    logic [DW-1:0] w_p;
    logic [31:0]   w_el, w_sp;
    logic [31:0]   w_pdiff;
    logic [TW:0]   w_free;
    logic          w_hasfree;
    logic [DW:0]   w_pfree;
    logic          w_haspfree;
    logic [14:0]   w_lvl;
    logic signed [17:0] w_rel;
    logic [14:0]   w_relsat;

    assign w_t  = r_ti[TW-1:0];
    assign w_p  = r_pi[DW-1:0];
    assign w_el = r_now - r_beg[w_t];
    assign w_sp = r_fin[w_t] - r_beg[w_t];
    assign w_pdiff = r_now - r_pdue[w_p];
    assign w_lvl = (r_cmd.volume > VOL_MAX) ? VOL_MAX : r_cmd.volume;
    assign w_rel = $signed({3'b000, r_vnow[w_t]}) + 18'($signed(r_cmd.amount));
    assign w_relsat = w_rel[17] ? 15'd0 :
                      (w_rel > $signed({3'b000, VOL_MAX})) ? VOL_MAX : w_rel[14:0];

    always_comb begin
        w_free = '0;
        w_hasfree = 1'b0;
        for (int k = TRACK_SLOTS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                w_free = (TW+1)'(k);
                w_hasfree = 1'b1;
            end
        end
        w_pfree = '0;
        w_haspfree = 1'b0;
        for (int k = DELAY_SLOTS - 1; k >= 0; k--) begin
            if (!r_pused[k]) begin
                w_pfree = (DW+1)'(k);
                w_haspfree = 1'b1;
            end
        end
    end

    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_now    <= '0;
            r_used   <= '0;
            r_ending <= '0;
            r_pused  <= '0;
            r_ovalid <= 1'b0;
            r_hold_v <= 1'b0;
            r_dstart <= 1'b0;
            r_ti     <= '0;
            r_pi     <= '0;
        end else begin
            r_dstart <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= i_cmd.data;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_ti  <= '0;
                    r_pi  <= '0;
                    unique case (t_mode'(r_cmd.mode))
                        M_TICK: begin
                            r_now   <= r_now + 32'd1;
                            r_state <= S_TSLOT;
                        end
                        M_FADE_IN: begin
                            r_ssnd  <= r_cmd.sound;
                            r_sdur  <= r_cmd.duration_ms;
                            r_slvl  <= w_lvl;
                            r_ret   <= S_FIN;
                            r_state <= S_START;
                        end
                        M_FADE_DLY: begin
                            if (!w_haspfree) begin
                                r_res   <= '{A_NO_SLOT, 3'd0, r_cmd.sound, 15'd0, 1'b1};
                                r_ret   <= S_FIN;
                                r_state <= S_EMIT;
                            end else begin
                                r_pused[w_pfree[DW-1:0]] <= 1'b1;
                                r_psnd[w_pfree[DW-1:0]]  <= r_cmd.sound;
                                r_plen[w_pfree[DW-1:0]]  <= r_cmd.duration_ms;
                                r_plvl[w_pfree[DW-1:0]]  <= w_lvl;
                                r_pdue[w_pfree[DW-1:0]]  <= r_now + 32'(r_cmd.delay_ms);
                                r_state <= S_FIN;
                            end
                        end
                        M_FADE_OUT, M_FADE_VOL: r_state <= S_FIND;
                        M_OUT_ALL: begin
                            r_pused <= '0;
                            r_state <= S_SCAN;
                        end
                        M_STOP_ALL: r_state <= S_SCAN;
                        default: r_state <= S_FIN;
                    endcase
                end
                S_FIND: begin
                    if (r_ti == (TW+1)'(TRACK_SLOTS)) begin
                        r_res   <= '{A_NOT_PLAY, 3'd0, r_cmd.sound, 15'd0, 1'b1};
                        r_ret   <= S_FIN;
                        r_state <= S_EMIT;
                    end else if (r_used[w_t] && r_snd[w_t] == r_cmd.sound) begin
                        r_beg[w_t]  <= r_now;
                        r_fin[w_t]  <= r_now + 32'(r_cmd.duration_ms);
                        r_from[w_t] <= r_vnow[w_t];
                        if (r_cmd.mode == M_FADE_OUT) begin
                            r_to[w_t]     <= '0;
                            r_ending[w_t] <= 1'b1;
                        end else begin
                            r_to[w_t] <= w_relsat;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_ti <= r_ti + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (r_ti == (TW+1)'(TRACK_SLOTS)) begin
                        if (r_cmd.mode == M_STOP_ALL) begin
                            r_used   <= '0;
                            r_ending <= '0;
                            r_pused  <= '0;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_ti <= r_ti + 1'b1;
                        if (r_used[w_t]) begin
                            if (r_cmd.mode == M_STOP_ALL) begin
                                r_res   <= '{A_STOP, 3'(w_t), r_snd[w_t], 15'd0, 1'b0};
                                r_ret   <= S_SCAN;
                                r_state <= S_EMIT;
                            end else begin
                                r_beg[w_t]    <= r_now;
                                r_fin[w_t]    <= r_now + 32'(r_cmd.duration_ms);
                                r_from[w_t]   <= r_vnow[w_t];
                                r_to[w_t]     <= '0;
                                r_ending[w_t] <= 1'b1;
                            end
                        end
                    end
                end
                S_TSLOT: begin
                    if (r_ti == (TW+1)'(TRACK_SLOTS)) begin
                        r_state <= S_TPEND;
                    end else if (!r_used[w_t]) begin
                        r_ti <= r_ti + 1'b1;
                    end else if (r_ending[w_t] && r_vnow[w_t] == 15'd0) begin
                        r_used[w_t]   <= 1'b0;
                        r_ending[w_t] <= 1'b0;
                        r_ti <= r_ti + 1'b1;
                    end else if (w_el >= w_sp) begin
                        r_vnow[w_t] <= r_to[w_t];
                        r_res   <= '{A_SET_VOL, 3'(w_t), r_snd[w_t], r_to[w_t], 1'b0};
                        r_ti    <= r_ti + 1'b1;
                        r_ret   <= S_TSLOT;
                        r_state <= S_EMIT;
                    end else if (w_el == 32'd0) begin
                        r_ti <= r_ti + 1'b1;
                    end else begin
                        // el*to + (sp-el)*from; products kept narrow, fits 48 bits
                        r_num    <= 48'(w_el * 47'(r_to[w_t]))
                                  + 48'((w_sp - w_el) * 47'(r_from[w_t]));
                        r_den    <= w_sp;
                        r_dstart <= 1'b1;
                        r_state  <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (w_ddone) begin
                        r_vnow[w_t] <= w_quo[14:0];
                        r_res   <= '{A_SET_VOL, 3'(w_t), r_snd[w_t], w_quo[14:0], 1'b0};
                        r_ti    <= r_ti + 1'b1;
                        r_ret   <= S_TSLOT;
                        r_state <= S_EMIT;
                    end
                end
                S_TPEND: begin
                    if (r_pi == (DW+1)'(DELAY_SLOTS)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_pi <= r_pi + 1'b1;
                        if (r_pused[w_p] && !w_pdiff[31]) begin
                            r_pused[w_p] <= 1'b0;
                            r_ssnd  <= r_psnd[w_p];
                            r_sdur  <= r_plen[w_p];
                            r_slvl  <= r_plvl[w_p];
                            r_ret   <= S_TPEND;
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    if (w_hasfree) begin
                        r_used[w_free[TW-1:0]]   <= 1'b1;
                        r_ending[w_free[TW-1:0]] <= 1'b0;
                        r_snd[w_free[TW-1:0]]    <= r_ssnd;
                        r_vnow[w_free[TW-1:0]]   <= '0;
                        r_from[w_free[TW-1:0]]   <= '0;
                        r_to[w_free[TW-1:0]]     <= r_slvl;
                        r_beg[w_free[TW-1:0]]    <= r_now;
                        r_fin[w_free[TW-1:0]]    <= r_now + 32'(r_sdur);
                        r_res <= '{A_START, 3'(w_free), r_ssnd,
                                   (r_sdur == 16'd0) ? r_slvl : 15'd0, 1'b0};
                    end else begin
                        r_res <= '{A_NO_SLOT, 3'd0, r_ssnd, 15'd0, 1'b0};
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    // new result in r_res; the one held before it goes out first
                    if (!r_hold_v) begin
                        r_hold   <= r_res;
                        r_hold_v <= 1'b1;
                        r_state  <= r_ret;
                    end else if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                    end else if (o_res.ready) begin
                        r_ovalid <= 1'b0;
                        r_hold   <= r_res;
                        r_state  <= r_ret;
                    end
                end
                S_FIN: begin
                    // the held result is the final one; commands with none go idle
                    if (!r_hold_v) begin
                        r_state <= S_IDLE;
                    end else if (!r_ovalid) begin
                        r_hold.last <= 1'b1;
                        r_ovalid    <= 1'b1;
                    end else if (o_res.ready) begin
                        r_ovalid <= 1'b0;
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- tb/multi_track_volume_fader_tb.sv -----
module multi_track_volume_fader_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mtvf_pkg::*;

    localparam int NTRK = 8;
    localparam int NDLY = 4;
    localparam int CYCLE_LIMIT = 4000000;

    logic i_clk;
    logic i_rst_n;
    mtvf_cmd_if cmd_ch ();
    mtvf_res_if res_ch ();

    multi_track_volume_fader uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // shadow state of the fader
    logic [31:0] clk_ms;
    logic        trk_used [NTRK];
    logic        trk_ending [NTRK];
    logic [7:0]  trk_sound [NTRK];
    logic [14:0] trk_from [NTRK];
    logic [14:0] trk_to [NTRK];
    logic [14:0] trk_vol [NTRK];
    logic [31:0] trk_begin [NTRK];
    logic [31:0] trk_finish [NTRK];
    logic        dly_used [NDLY];
    logic [7:0]  dly_sound [NDLY];
    logic [15:0] dly_len [NDLY];
    logic [14:0] dly_level [NDLY];
    logic [31:0] dly_due [NDLY];

    t_res pending_res [$];
    t_res new_res [$];
    int   mismatches;
    int   cycles;
    bit   done;

    function automatic void add_new(t_res r);
        new_res.insert(new_res.size(), r);
    endfunction

    function automatic void add_pending(t_res r);
        pending_res.insert(pending_res.size(), r);
    endfunction

    function automatic t_res mk_res(t_action a, int s, logic [7:0] snd, logic [14:0] v);
        t_res r;
        r.action     = a;
        r.slot       = s[2:0];
        r.sound_out  = snd;
        r.volume_out = v;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic int match_sound(logic [7:0] snd);
        for (int i = 0; i < NTRK; i++)
            if (trk_used[i] && trk_sound[i] == snd) return i;
        return -1;
    endfunction

    task automatic start_track(logic [7:0] snd, logic [15:0] dur, logic [14:0] lvl);
        logic [14:0] l;
        l = (lvl > VOL_MAX) ? VOL_MAX : lvl;
        for (int i = 0; i < NTRK; i++) begin
            if (!trk_used[i]) begin
                trk_used[i] = 1; trk_ending[i] = 0; trk_sound[i] = snd;
                trk_vol[i] = 0; trk_from[i] = 0; trk_to[i] = l;
                trk_begin[i] = clk_ms; trk_finish[i] = clk_ms + 32'(dur);
                add_new(mk_res(A_START, i, snd, dur == 0 ? l : 15'd0));
                return;
            end
        end
        add_new(mk_res(A_NO_SLOT, 0, snd, 0));
    endtask

    task automatic retarget(int i, logic [15:0] dur, logic [14:0] tgt);
        trk_begin[i] = clk_ms; trk_finish[i] = clk_ms + 32'(dur);
        trk_from[i] = trk_vol[i]; trk_to[i] = tgt;
    endtask

    task automatic fader_step(t_cmd c);
        logic [31:0] el, span;
        logic [63:0] acc;
        int k, t;
        new_res.delete();
        case (t_mode'(c.mode))
            M_TICK: begin
                clk_ms = clk_ms + 32'd1;
                for (int i = 0; i < NTRK; i++) begin
                    if (!trk_used[i]) continue;
                    if (trk_ending[i] && trk_vol[i] == 0) begin
                        trk_used[i] = 0; trk_ending[i] = 0; continue;
                    end
                    el = clk_ms - trk_begin[i];
                    span = trk_finish[i] - trk_begin[i];
                    if (el >= span) trk_vol[i] = trk_to[i];
                    else if (el > 0) begin
                        acc = 64'(el) * 64'(trk_to[i]) + 64'(span - el) * 64'(trk_from[i]);
                        trk_vol[i] = 15'(acc / 64'(span));
                    end else continue;
                    add_new(mk_res(A_SET_VOL, i, trk_sound[i], trk_vol[i]));
                end
                for (int i = 0; i < NDLY; i++) begin
                    if (dly_used[i] && ((clk_ms - dly_due[i]) & 32'h8000_0000) == 0) begin
                        dly_used[i] = 0;
                        start_track(dly_sound[i], dly_len[i], dly_level[i]);
                    end
                end
            end
            M_FADE_IN: start_track(c.sound, c.duration_ms, c.volume);
            M_FADE_DLY: begin
                k = -1;
                for (int i = NDLY - 1; i >= 0; i--) if (!dly_used[i]) k = i;
                if (k < 0) add_new(mk_res(A_NO_SLOT, 0, c.sound, 0));
                else begin
                    dly_used[k] = 1; dly_sound[k] = c.sound; dly_len[k] = c.duration_ms;
                    dly_level[k] = (c.volume > VOL_MAX) ? VOL_MAX : c.volume;
                    dly_due[k] = clk_ms + 32'(c.delay_ms);
                end
            end
            M_FADE_OUT: begin
                k = match_sound(c.sound);
                if (k < 0) add_new(mk_res(A_NOT_PLAY, 0, c.sound, 0));
                else begin
                    retarget(k, c.duration_ms, 0);
                    trk_ending[k] = 1;
                end
            end
            M_FADE_VOL: begin
                k = match_sound(c.sound);
                if (k < 0) add_new(mk_res(A_NOT_PLAY, 0, c.sound, 0));
                else begin
                    t = int'(trk_vol[k]) + int'($signed(c.amount));
                    if (t < 0) t = 0;
                    if (t > int'(VOL_MAX)) t = int'(VOL_MAX);
                    retarget(k, c.duration_ms, 15'(t));
                end
            end
            M_OUT_ALL: begin
                for (int i = 0; i < NDLY; i++) dly_used[i] = 0;
                for (int i = 0; i < NTRK; i++)
                    if (trk_used[i]) begin
                        retarget(i, c.duration_ms, 0);
                        trk_ending[i] = 1;
                    end
            end
            M_STOP_ALL: begin
                for (int i = 0; i < NTRK; i++)
                    if (trk_used[i]) add_new(mk_res(A_STOP, i, trk_sound[i], 0));
                for (int i = 0; i < NTRK; i++) begin
                    trk_used[i] = 0; trk_ending[i] = 0;
                end
                for (int i = 0; i < NDLY; i++) dly_used[i] = 0;
            end
            default: ;
        endcase
        if (new_res.size() > 0) new_res[new_res.size() - 1].last = 1'b1;
    endtask

    // directed rows; a nonzero fixed_n means the expected result is typed in
    typedef struct {
        t_cmd cmd;
        int   fixed_n;
        t_res fixed_res;
    } t_row;

    function automatic t_cmd mk_cmd(t_mode m, logic [7:0] s, logic [15:0] d,
                                    logic [14:0] v, logic [15:0] a, logic [15:0] dl);
        t_cmd c;
        c.mode = m; c.sound = s; c.duration_ms = d;
        c.volume = v; c.amount = a; c.delay_ms = dl;
        return c;
    endfunction

    function automatic t_res fin(t_res r);
        r.last = 1'b1;
        return r;
    endfunction

    t_row rows [$];

    function automatic void add_row(t_cmd c, int n, t_res r);
        t_row w;
        w.cmd = c;
        w.fixed_n = n;
        w.fixed_res = r;
        rows.insert(rows.size(), w);
    endfunction

    function automatic t_cmd rand_cmd(int sel);
        t_cmd c;
        c.sound       = 8'($urandom_range(0, 5));
        if ($urandom_range(0, 15) == 0) c.sound = 8'($urandom);
        c.duration_ms = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        c.volume      = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 25600));
        c.amount      = 16'($urandom_range(0, 51200) - 25600);
        if ($urandom_range(0, 19) == 0) c.amount = 16'($urandom);
        c.delay_ms    = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10));
        if (sel < 45) c.mode = M_TICK;
        else if (sel < 65) c.mode = M_FADE_IN;
        else if (sel < 75) c.mode = M_FADE_DLY;
        else if (sel < 84) c.mode = M_FADE_OUT;
        else if (sel < 94) c.mode = M_FADE_VOL;
        else if (sel < 97) c.mode = M_OUT_ALL;
        else if (sel < 99) c.mode = M_STOP_ALL;
        else c.mode = M_UNUSED;
        return c;
    endfunction

    task automatic send_cmd(t_cmd c);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        fader_step(c);
        foreach (new_res[j]) add_pending(new_res[j]);
    endtask

    task automatic maybe_gap(ref int burst);
        int g;
        if (burst > 0) begin
            burst--;
            return;
        end
        burst = $urandom_range(0, 12);
        g = $urandom_range(0, 6);
        if (g > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // receiver stall pattern
    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            case (cycles / 3000 % 3)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                default: res_ch.ready <= ((cycles % 7) < 3);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", res_ch.data);
            end else begin
                exp_r = pending_res.pop_front();
                if (res_ch.data !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, res_ch.data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT && !done) begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_cmd c;
        int burst;
        int sent;
        int tail;
        mismatches = 0;
        cycles = 0;
        done = 0;
        burst = 0;
        clk_ms = 0;
        for (int i = 0; i < NTRK; i++) begin
            trk_used[i] = 0; trk_ending[i] = 0;
        end
        for (int i = 0; i < NDLY; i++) dly_used[i] = 0;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset: empty table
        add_row(mk_cmd(M_FADE_OUT, 8'd9, 0, 0, 0, 0), 1,
                fin(mk_res(A_NOT_PLAY, 0, 8'd9, 0)));
        add_row(mk_cmd(M_FADE_VOL, 8'hFF, 0, 0, 16'h7FFF, 0), 1,
                fin(mk_res(A_NOT_PLAY, 0, 8'hFF, 0)));
        add_row(mk_cmd(M_TICK, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_cmd(M_FADE_IN, 8'd0, 0, 15'h7FFF, 0, 0), 1,
                fin(mk_res(A_START, 0, 8'd0, VOL_MAX)));
        add_row(mk_cmd(M_FADE_IN, 8'hFF, 16'hFFFF, 15'd0, 0, 0), 1,
                fin(mk_res(A_START, 1, 8'hFF, 0)));
        for (int i = 2; i < NTRK; i++)
            add_row(mk_cmd(M_FADE_IN, 8'(i), 16'd4, 15'd25600, 0, 0), 0, '0);
        add_row(mk_cmd(M_FADE_IN, 8'd77, 0, 15'd100, 0, 0), 1,
                fin(mk_res(A_NO_SLOT, 0, 8'd77, 0)));
        add_row(mk_cmd(M_TICK, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_cmd(M_FADE_VOL, 8'd2, 16'd3, 0, 16'h8000, 0), 0, '0);
        add_row(mk_cmd(M_FADE_VOL, 8'd3, 16'd0, 0, 16'h7FFF, 0), 0, '0);
        add_row(mk_cmd(M_FADE_OUT, 8'd4, 16'd2, 0, 0, 0), 0, '0);
        add_row(mk_cmd(M_TICK, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_cmd(M_TICK, 0, 0, 0, 0, 0), 0, '0);
        for (int i = 0; i < 5; i++)
            add_row(mk_cmd(M_FADE_DLY, 8'(20 + i), 16'd2, 15'h7FFF, 0,
                           i == 0 ? 16'hFFFF : 16'd1), 0, '0);
        add_row(mk_cmd(M_UNUSED, 8'hFF, 16'hFFFF, 15'h7FFF, 16'hFFFF, 16'hFFFF), 0, '0);
        add_row(mk_cmd(M_STOP_ALL, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_cmd(M_TICK, 0, 0, 0, 0, 0), 0, '0);

        foreach (rows[r]) begin
            if (rows[r].fixed_n > 0) begin
                fader_step(rows[r].cmd);
                if (new_res.size() != 1 || new_res[0] !== rows[r].fixed_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d: model disagrees with table", r);
                end
                // model already stepped: drive the command directly, without double counting
                add_pending(rows[r].fixed_res);
                cmd_ch.valid <= 1'b1;
                cmd_ch.data  <= rows[r].cmd;
                @(posedge i_clk);
                while (!cmd_ch.ready) @(posedge i_clk);
            end else begin
                send_cmd(rows[r].cmd);
            end
            maybe_gap(burst);
        end

        sent = 0;
        while (sent < 450) begin
            c = rand_cmd($urandom_range(0, 99));
            send_cmd(c);
            sent++;
            if (sent == 200) begin
                cmd_ch.valid <= 1'b0;
                while (pending_res.size() > 0) @(posedge i_clk);
            end
            maybe_gap(burst);
        end
        cmd_ch.valid <= 1'b0;

        tail = 0;
        while (pending_res.size() > 0 && tail < 200000) begin
            @(posedge i_clk);
            tail++;
        end
        repeat (600) @(posedge i_clk);
        done = 1;
        if (mismatches == 0 && pending_res.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- multi_track_volume_fader.f -----
rtl/mtvf_pkg.sv
rtl/mtvf_if.sv
rtl/mtvf_div.sv
rtl/multi_track_volume_fader.sv
tb/multi_track_volume_fader_tb.sv
